@@ rtl/core/pdsn_pkg.sv @@
`default_nettype none

package pdsn_pkg;

  // Command codes carried in s_axis_tuser
  localparam logic [1:0] CMD_BASE = 2'd0;
  localparam logic [1:0] CMD_NEW  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_ABS = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // Resolver phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_BASE      = 3'd1;
  localparam logic [2:0] PH_BASE_HOLD = 3'd2;
  localparam logic [2:0] PH_READY     = 3'd3;
  localparam logic [2:0] PH_NEW       = 3'd4;
  localparam logic [2:0] PH_NEW_HOLD  = 3'd5;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [8:0] CAP_RESET  = 9'd256;
  localparam logic [8:0] LEN_SAT    = 9'd511;
  localparam int unsigned NUM_SLOTS = 5;

  typedef struct packed {
    logic push;
    logic push2;
    logic pop;
  } stk_op_t;

endpackage

`default_nettype wire

@@ rtl/core/pdsn_seg_stack.sv @@
`default_nettype none

module pdsn_seg_stack #(
  parameter int unsigned BUFFER_BYTES = 256,
  parameter int unsigned MAX_DEPTH    = 128
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  pdsn_pkg::stk_op_t                  op_i,
  input  wire [$clog2(MAX_DEPTH+1)-1:0]      depth_i,
  input  wire [$clog2(BUFFER_BYTES)-1:0]     push_data_i,
  input  wire [$clog2(BUFFER_BYTES)-1:0]     push2_data_i,
  output logic [$clog2(BUFFER_BYTES)-1:0]    top_o
);
  import pdsn_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned SW = $clog2(MAX_DEPTH);

  logic [AW-1:0] mem [MAX_DEPTH];
  logic [AW-1:0] top_q;
  logic [AW-1:0] rd_q;
  logic          pend_q;
  logic          fl_q;
  logic [SW-1:0] fl_a_q;
  logic [DW-1:0] below;
  logic          we;
  logic [SW-1:0] wa;
  logic [AW-1:0] wdat;

  // top entry is cached; after a pop the new top arrives from the RAM in the next cycle
  assign top_o = pend_q ? rd_q : top_q;
  assign below = depth_i - DW'(2);

  // a second push in one transfer leaves its entry in the cache and lands in the
  // RAM the next cycle, while the store drain holds the input
  assign we   = op_i.push || fl_q;
  assign wa   = fl_q ? fl_a_q : depth_i[SW-1:0];
  assign wdat = fl_q ? top_q : push_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wdat;
    end
    if (op_i.pop && depth_i >= DW'(2)) begin
      rd_q <= mem[below[SW-1:0]];
    end
    if (op_i.push) begin
      top_q <= op_i.push2 ? push2_data_i : push_data_i;
    end else if (pend_q) begin
      top_q <= rd_q;
    end
    if (op_i.push && op_i.push2) begin
      fl_a_q <= depth_i[SW-1:0] + SW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      fl_q   <= 1'b0;
    end else begin
      pend_q <= op_i.pop && !op_i.push && depth_i >= DW'(2);
      fl_q   <= op_i.push && op_i.push2;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pdsn_path_store.sv @@
`default_nettype none

module pdsn_path_store #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  wire                                                clk_i,
  input  wire                                                rst_ni,
  input  wire                                                load_i,
  input  wire [pdsn_pkg::NUM_SLOTS-1:0]                      wr_v_i,
  input  wire [pdsn_pkg::NUM_SLOTS-1:0][$clog2(BUFFER_BYTES)-1:0] wr_a_i,
  input  wire [pdsn_pkg::NUM_SLOTS-1:0][7:0]                 wr_d_i,
  input  wire                                                rd_en_i,
  input  wire [$clog2(BUFFER_BYTES)-1:0]                     rd_addr_i,
  output logic [7:0]                                         rd_data_o,
  output logic                                               busy_o
);
  import pdsn_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  logic [7:0]                      mem [BUFFER_BYTES];
  logic [NUM_SLOTS-1:0]            pv_q;
  logic [NUM_SLOTS-1:0][AW-1:0]    pa_q;
  logic [NUM_SLOTS-1:0][7:0]       pd_q;
  logic [NUM_SLOTS-1:0]            src_v;
  logic [NUM_SLOTS-1:0][AW-1:0]    src_a;
  logic [NUM_SLOTS-1:0][7:0]       src_d;
  logic [NUM_SLOTS-1:0]            rem_v;
  logic [$clog2(NUM_SLOTS)-1:0]    sel;
  logic                            we;
  logic [7:0]                      rd_q;

  assign busy_o    = |pv_q;
  assign rd_data_o = rd_q;

  // one write per cycle: first the new item's earliest write, the rest drain in order
  always_comb begin
    if (busy_o) begin
      src_v = pv_q;
      src_a = pa_q;
      src_d = pd_q;
    end else begin
      src_v = load_i ? wr_v_i : '0;
      src_a = wr_a_i;
      src_d = wr_d_i;
    end
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (src_v[i]) begin
        sel = ($clog2(NUM_SLOTS))'(i);
      end
    end
    we    = |src_v;
    rem_v = src_v;
    rem_v[sel] = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[src_a[sel]] <= src_d[sel];
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
    if (!busy_o && load_i) begin
      pa_q <= wr_a_i;
      pd_q <= wr_d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (busy_o || load_i) begin
      pv_q <= rem_v;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pdsn_resolve.sv @@
`default_nettype none

module pdsn_resolve #(
  parameter int unsigned BUFFER_BYTES = 256,
  parameter int unsigned MAX_DEPTH    = 128
) (
  input  wire                                                clk_i,
  input  wire                                                rst_ni,
  input  wire                                                accept_i,
  input  wire [1:0]                                          cmd_i,
  input  wire [7:0]                                          char_i,
  input  wire                                                last_i,
  input  wire                                                cfg_we_i,
  input  wire [8:0]                                          cfg_data_i,
  input  wire [$clog2(BUFFER_BYTES)-1:0]                     top_i,
  output logic                                               done_o,
  output logic [1:0]                                         status_o,
  output logic [8:0]                                         len_o,
  output logic [7:0]                                         cnt_o,
  output logic [pdsn_pkg::NUM_SLOTS-1:0]                     wr_v_o,
  output logic [pdsn_pkg::NUM_SLOTS-1:0][$clog2(BUFFER_BYTES)-1:0] wr_a_o,
  output logic [pdsn_pkg::NUM_SLOTS-1:0][7:0]                wr_d_o,
  output pdsn_pkg::stk_op_t                                  stk_op_o,
  output logic [$clog2(BUFFER_BYTES)-1:0]                    push_data_o,
  output logic [$clog2(BUFFER_BYTES)-1:0]                    push2_data_o,
  output logic [$clog2(MAX_DEPTH+1)-1:0]                     depth_o
);
  import pdsn_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned NW = ((AW > 9) ? AW : 9) + 2;

  typedef struct packed {
    logic [AW-1:0] wc;
    logic [DW-1:0] depth;
    logic [8:0]    seg;
    logic          dots;
    logic [8:0]    need;
    logic [1:0]    fault;
  } st_t;

  typedef struct packed {
    st_t           s;
    logic          wv;
    logic [AW-1:0] wa;
    logic [7:0]    wd;
    logic          push;
    logic          pop;
    logic          hold;
  } step_t;

  st_t        st_q, st_d;
  logic [2:0] phase_q, phase_d;
  logic [8:0] cap_q;
  logic [NW-1:0] cap;

  function automatic step_t fin(st_t s, logic [AW-1:0] top, logic [NW-1:0] c);
    step_t r;
    logic [NW-1:0] need;
    r      = '0;
    r.s    = s;
    r.wa   = s.wc;
    r.wd   = CH_SLASH;
    need   = NW'(s.wc) + NW'(s.seg) + NW'(1);
    if (s.seg != 9'd0 && !(s.dots && s.seg == 9'd1)) begin
      if (s.dots && s.seg == 9'd2) begin
        if (s.depth != '0) begin
          r.s.depth = s.depth - DW'(1);
          r.s.wc    = top;
          r.pop     = 1'b1;
        end
      end else if (need + NW'(1) > c || s.depth >= DW'(MAX_DEPTH)) begin
        r.s.fault = ST_OVF;
        r.s.need  = (need > NW'(LEN_SAT)) ? LEN_SAT : need[8:0];
      end else begin
        r.wv      = 1'b1;
        r.push    = 1'b1;
        r.s.depth = s.depth + DW'(1);
        r.s.wc    = need[AW-1:0];
      end
    end
    r.s.seg  = 9'd0;
    r.s.dots = 1'b1;
    return r;
  endfunction

  function automatic step_t feed(st_t s, logic [7:0] ch, logic [AW-1:0] top,
                                 logic [NW-1:0] c);
    step_t r;
    logic [NW-1:0] idx;
    idx = NW'(s.wc) + NW'(1) + NW'(s.seg);
    if (ch == CH_NUL || ch == CH_SLASH) begin
      r = fin(s, top, c);
    end else begin
      r      = '0;
      r.s    = s;
      r.wv   = idx < c;
      r.wa   = idx[AW-1:0];
      r.wd   = ch;
      r.s.dots = s.dots && (ch == CH_DOT);
      r.s.seg  = (s.seg == LEN_SAT) ? LEN_SAT : s.seg + 9'd1;
    end
    r.hold = (ch == CH_NUL) || (r.s.fault != ST_OK);
    return r;
  endfunction

  function automatic st_t root(st_t s);
    st_t r;
    r       = s;
    r.wc    = '0;
    r.depth = '0;
    r.fault = ST_OK;
    r.need  = 9'd0;
    r.seg   = 9'd0;
    r.dots  = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] sat_cnt(logic [DW-1:0] d);
    logic [DW+7:0] x;
    x = (DW + 8)'(d);
    return (x > (DW + 8)'(255)) ? 8'hFF : x[7:0];
  endfunction

  always_comb begin
    if (cap_q < 9'd2) begin
      cap = NW'(2);
    end else if (NW'(cap_q) > NW'(BUFFER_BYTES)) begin
      cap = NW'(BUFFER_BYTES);
    end else begin
      cap = NW'(cap_q);
    end
  end

  always_comb begin
    step_t         f;
    logic          brdy;
    logic [AW-1:0] l;
    st_d         = st_q;
    phase_d      = phase_q;
    wr_v_o       = '0;
    wr_a_o       = '0;
    wr_d_o       = '0;
    stk_op_o     = '0;
    push_data_o  = st_q.wc;
    push2_data_o = '0;
    done_o       = 1'b0;
    status_o     = ST_OK;
    len_o        = 9'd0;
    cnt_o        = 8'd0;
    f            = '0;
    brdy         = 1'b0;
    l            = '0;
    // write slots in program order: pending base segment, root, byte, closing segment,
    // terminator
    unique case (cmd_i)
      CMD_BASE: begin
        if (phase_q != PH_BASE && phase_q != PH_BASE_HOLD) begin
          st_d      = root(st_d);
          wr_v_o[1] = 1'b1;
          wr_a_o[1] = '0;
          wr_d_o[1] = CH_SLASH;
          if (char_i == CH_SLASH) begin
            phase_d = PH_BASE;
          end else begin
            st_d.fault = ST_ABS;
            phase_d    = PH_BASE_HOLD;
          end
        end else if (phase_q == PH_BASE) begin
          f         = feed(st_d, char_i, top_i, cap);
          st_d      = f.s;
          wr_v_o[2] = f.wv;
          wr_a_o[2] = f.wa;
          wr_d_o[2] = f.wd;
          if (f.push) stk_op_o.push = 1'b1;
          if (f.pop)  stk_op_o.pop  = 1'b1;
          if (f.hold) phase_d = PH_BASE_HOLD;
        end
        if (last_i) begin
          if (phase_d == PH_BASE) begin
            f         = fin(st_d, top_i, cap);
            st_d      = f.s;
            wr_v_o[3] = f.wv;
            wr_a_o[3] = f.wa;
            wr_d_o[3] = f.wd;
            if (f.push) stk_op_o.push = 1'b1;
            if (f.pop)  stk_op_o.pop  = 1'b1;
          end
          phase_d = PH_READY;
        end
      end
      CMD_NEW: begin
        if (phase_q != PH_NEW && phase_q != PH_NEW_HOLD) begin
          brdy = (phase_q == PH_BASE) || (phase_q == PH_BASE_HOLD) ||
                 (phase_q == PH_READY);
          if (phase_q == PH_BASE) begin
            f         = fin(st_d, top_i, cap);
            st_d      = f.s;
            wr_v_o[0] = f.wv;
            wr_a_o[0] = f.wa;
            wr_d_o[0] = f.wd;
            if (f.push) stk_op_o.push = 1'b1;
            if (f.pop)  stk_op_o.pop  = 1'b1;
          end
          if (char_i == CH_SLASH) begin
            st_d      = root(st_d);
            wr_v_o[1] = 1'b1;
            wr_a_o[1] = '0;
            wr_d_o[1] = CH_SLASH;
            phase_d   = PH_NEW;
          end else if (brdy && st_d.fault == ST_OK) begin
            f         = feed(st_d, char_i, top_i, cap);
            st_d      = f.s;
            wr_v_o[2] = f.wv;
            wr_a_o[2] = f.wa;
            wr_d_o[2] = f.wd;
            if (f.push) stk_op_o.push = 1'b1;
            if (f.pop)  stk_op_o.pop  = 1'b1;
            phase_d = f.hold ? PH_NEW_HOLD : PH_NEW;
          end else begin
            if (!(brdy && st_d.fault == ST_OVF)) st_d.fault = ST_ABS;
            phase_d = PH_NEW_HOLD;
          end
        end else if (phase_q == PH_NEW) begin
          f         = feed(st_d, char_i, top_i, cap);
          st_d      = f.s;
          wr_v_o[2] = f.wv;
          wr_a_o[2] = f.wa;
          wr_d_o[2] = f.wd;
          if (f.push) stk_op_o.push = 1'b1;
          if (f.pop)  stk_op_o.pop  = 1'b1;
          if (f.hold) phase_d = PH_NEW_HOLD;
        end
        if (last_i) begin
          if (phase_d == PH_NEW) begin
            push2_data_o = st_d.wc;
            f         = fin(st_d, top_i, cap);
            st_d      = f.s;
            wr_v_o[3] = f.wv;
            wr_a_o[3] = f.wa;
            wr_d_o[3] = f.wd;
            // this can follow a stack op of the base segment closed by the same byte:
            // push after push needs a second entry, push after pop restores the old top
            if (f.push) begin
              if (stk_op_o.push) begin
                stk_op_o.push2 = 1'b1;
              end else if (stk_op_o.pop) begin
                stk_op_o.pop = 1'b0;
              end else begin
                stk_op_o.push = 1'b1;
              end
            end
            if (f.pop)  stk_op_o.pop  = 1'b1;
          end
          done_o   = 1'b1;
          status_o = st_d.fault;
          if (st_d.fault == ST_OK) begin
            l         = (st_d.wc == '0) ? AW'(1) : st_d.wc;
            wr_v_o[4] = 1'b1;
            wr_a_o[4] = l;
            wr_d_o[4] = CH_NUL;
            len_o     = 9'((NW)'(l));
            cnt_o     = sat_cnt(st_d.depth);
            phase_d   = PH_READY;
          end else begin
            if (st_d.fault == ST_OVF) begin
              len_o = st_d.need;
              cnt_o = sat_cnt(st_d.depth);
            end
            phase_d = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign depth_o = st_q.depth;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '0;
      phase_q <= PH_IDLE;
      cap_q   <= CAP_RESET;
    end else begin
      if (accept_i) begin
        st_q    <= st_d;
        phase_q <= phase_d;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/path_dot_segment_normalizer_unit.sv @@
`default_nettype none

// Byte-serial path resolver. Base path bytes (tuser 0), then new path bytes
// (tuser 1), each part closed by tlast, build the normalized absolute path in an
// on-chip byte store; the result of the new path's tlast byte carries status,
// length and component count, and tuser 2 reads stored bytes back. One result
// transfer leaves per input transfer, valid from the cycle after it. Throughput is
// one byte per cycle while the output is not stalled; the store has a single write
// port, so a byte that causes several store writes holds s_axis_tready low until
// the store has drained every write beyond the first. The most writes come from the
// closing byte of a new path that also closes an open base component: separator,
// byte, separator and terminator. Segment starts live in a second RAM with a cached
// top entry. No clearing pass after reset.
module path_dot_segment_normalizer_unit #(
  parameter int unsigned BUFFER_BYTES = 256,
  parameter int unsigned MAX_DEPTH    = 128
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,  // char_in[7:0], read_index[15:8]
  input  wire  [1:0]  s_axis_tuser,  // cmd[1:0]
  input  wire         s_axis_tlast,  // last
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result_length[8:0], component_count[16:9],
                                     // read_byte[24:17], zero[31:25]
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  output logic        m_axis_tlast,  // done_res
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [8:0]  cfg_data_i     // out_capacity
);
  import pdsn_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned NW = ((AW > 9) ? AW : 9) + 2;

  logic                          accept;
  logic                          busy;
  logic                          done;
  logic [1:0]                    status;
  logic [8:0]                    len;
  logic [7:0]                    cnt;
  logic [NUM_SLOTS-1:0]          wr_v;
  logic [NUM_SLOTS-1:0][AW-1:0]  wr_a;
  logic [NUM_SLOTS-1:0][7:0]     wr_d;
  stk_op_t                       stk_op;
  logic [AW-1:0]                 push_data;
  logic [AW-1:0]                 push2_data;
  logic [DW-1:0]                 depth;
  logic [AW-1:0]                 top;
  logic                          rd_en;
  logic [7:0]                    rd_data;
  logic                          out_v_q;
  logic                          done_q;
  logic [1:0]                    status_q;
  logic [8:0]                    len_q;
  logic [7:0]                    cnt_q;
  logic                          rsel_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !busy && (!out_v_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rd_en         = accept && s_axis_tuser == CMD_READ &&
                         NW'(s_axis_tdata[15:8]) < NW'(BUFFER_BYTES);

  pdsn_resolve #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .MAX_DEPTH   (MAX_DEPTH)
  ) u_resolve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (s_axis_tuser),
    .char_i      (s_axis_tdata[7:0]),
    .last_i      (s_axis_tlast),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .top_i       (top),
    .done_o      (done),
    .status_o    (status),
    .len_o       (len),
    .cnt_o       (cnt),
    .wr_v_o      (wr_v),
    .wr_a_o      (wr_a),
    .wr_d_o      (wr_d),
    .stk_op_o    (stk_op),
    .push_data_o (push_data),
    .push2_data_o(push2_data),
    .depth_o     (depth)
  );

  pdsn_seg_stack #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .MAX_DEPTH   (MAX_DEPTH)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (accept ? stk_op : '0),
    .depth_i     (depth),
    .push_data_i (push_data),
    .push2_data_i(push2_data),
    .top_o       (top)
  );

  pdsn_path_store #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .wr_v_i   (wr_v),
    .wr_a_i   (wr_a),
    .wr_d_i   (wr_d),
    .rd_en_i  (rd_en),
    .rd_addr_i(AW'(s_axis_tdata[15:8])),
    .rd_data_o(rd_data),
    .busy_o   (busy)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      done_q   <= done;
      status_q <= status;
      len_q    <= len;
      cnt_q    <= cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      rsel_q  <= 1'b0;
    end else begin
      if (accept) begin
        out_v_q <= 1'b1;
        rsel_q  <= rd_en;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = done_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {7'd0, (rsel_q ? rd_data : 8'd0), cnt_q, len_q};

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import pdsn_pkg::*;

  localparam logic [1:0] CMD_NOP     = 2'd3;
  localparam int unsigned STORE_BYTES = 256;
  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned DRAIN_WAIT  = 16;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic       done;
    logic [1:0] status;
    logic [8:0] len;
    logic [7:0] count;
    logic [7:0] rbyte;
  } path_result_t;

  // Tracks the resolver state and keeps the results it predicts in order.
  class path_scoreboard;
    logic [7:0]  store[STORE_BYTES];
    bit          written[STORE_BYTES];
    int unsigned seg_starts[STACK_DEPTH];
    int unsigned wcur, depth, seglen, needed;
    bit          dots;
    logic [2:0]  phase;
    logic [1:0]  fault;
    logic [8:0]  cap;
    path_result_t pending[$];
    int unsigned errors, n_in, n_out, n_done, n_ovf, n_abs, n_reads;
    int unsigned last_len;

    function new();
      foreach (store[i]) begin
        store[i] = '0;
        written[i] = 1'b0;
      end
      wcur = 0; depth = 0; seglen = 0; needed = 0; dots = 0;
      phase = PH_IDLE; fault = ST_OK; cap = CAP_RESET;
      errors = 0; n_in = 0; n_out = 0; n_done = 0; n_ovf = 0; n_abs = 0;
      n_reads = 0; last_len = 1;
    endfunction

    function int unsigned cap_eff();
      int unsigned c;
      c = cap;
      if (c < 2) c = 2;
      if (c > STORE_BYTES) c = STORE_BYTES;
      return c;
    endfunction

    function void put(int unsigned idx, logic [7:0] v);
      store[idx] = v;
      written[idx] = 1'b1;
    endfunction

    function void seg_clear();
      seglen = 0;
      dots = 1'b1;
    endfunction

    function void go_root();
      wcur = 0;
      depth = 0;
      put(0, CH_SLASH);
      fault = ST_OK;
      needed = 0;
      seg_clear();
    endfunction

    function void add_char(logic [7:0] ch);
      int unsigned idx;
      idx = wcur + 1 + seglen;
      if (idx < cap_eff()) put(idx, ch);
      if (ch != CH_DOT) dots = 1'b0;
      if (seglen < LEN_SAT) seglen++;
    endfunction

    function void finish_segment();
      int unsigned need;
      if (seglen == 0) begin
        seg_clear();
        return;
      end
      if (dots && seglen == 1) begin
      end else if (dots && seglen == 2) begin
        if (depth > 0) begin
          depth--;
          wcur = seg_starts[depth];
        end
      end else begin
        need = wcur + seglen + 1;
        if (need + 1 > cap_eff() || depth >= STACK_DEPTH) begin
          fault = ST_OVF;
          needed = (need > LEN_SAT) ? LEN_SAT : need;
        end else begin
          put(wcur, CH_SLASH);
          seg_starts[depth] = wcur;
          depth++;
          wcur = need;
        end
      end
      seg_clear();
    endfunction

    // true when the running part has to hold until its last byte
    function bit feed(logic [7:0] ch);
      if (ch == CH_NUL) begin
        finish_segment();
        return 1'b1;
      end
      if (ch == CH_SLASH) finish_segment();
      else add_char(ch);
      return fault != ST_OK;
    endfunction

    function void note_input(logic [1:0] c, logic [7:0] ch, bit lst, logic [7:0] ri);
      path_result_t r;
      bit base_ready;
      int unsigned l;
      r = '0;
      n_in++;
      case (c)
        CMD_BASE: begin
          if (phase != PH_BASE && phase != PH_BASE_HOLD) begin
            go_root();
            if (ch == CH_SLASH) phase = PH_BASE;
            else begin
              fault = ST_ABS;
              phase = PH_BASE_HOLD;
            end
          end else if (phase == PH_BASE) begin
            if (feed(ch)) phase = PH_BASE_HOLD;
          end
          if (lst) begin
            if (phase == PH_BASE) finish_segment();
            phase = PH_READY;
          end
        end
        CMD_NEW: begin
          if (phase != PH_NEW && phase != PH_NEW_HOLD) begin
            base_ready = (phase == PH_BASE || phase == PH_BASE_HOLD ||
                          phase == PH_READY);
            if (phase == PH_BASE) finish_segment();
            if (ch == CH_SLASH) begin
              go_root();
              phase = PH_NEW;
            end else if (base_ready && fault == ST_OK) begin
              phase = PH_NEW;
              if (feed(ch)) phase = PH_NEW_HOLD;
            end else begin
              if (!(base_ready && fault == ST_OVF)) fault = ST_ABS;
              phase = PH_NEW_HOLD;
            end
          end else if (phase == PH_NEW) begin
            if (feed(ch)) phase = PH_NEW_HOLD;
          end
          if (lst) begin
            if (phase == PH_NEW) finish_segment();
            r.done = 1'b1;
            r.status = fault;
            n_done++;
            if (fault == ST_OK) begin
              l = (wcur != 0) ? wcur : 1;
              if (l < STORE_BYTES) put(l, CH_NUL);
              r.len = 9'(l);
              r.count = (depth > 255) ? 8'd255 : 8'(depth);
              last_len = l;
              phase = PH_READY;
            end else begin
              if (fault == ST_OVF) begin
                r.len = 9'(needed);
                r.count = (depth > 255) ? 8'd255 : 8'(depth);
                n_ovf++;
              end else n_abs++;
              phase = PH_IDLE;
            end
          end
        end
        CMD_READ: begin
          r.rbyte = store[ri];
          n_reads++;
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(path_result_t act);
      path_result_t exp_r;
      n_out++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: done=%0d st=%0d len=%0d cnt=%0d rd=%02h",
                 $time, act.done, act.status, act.len, act.count, act.rbyte);
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r !== act) begin
        errors++;
        $display("%0t: expected done=%0d st=%0d len=%0d cnt=%0d rd=%02h,",
                 $time, exp_r.done, exp_r.status, exp_r.len, exp_r.count, exp_r.rbyte);
        $display("%0t:   actual done=%0d st=%0d len=%0d cnt=%0d rd=%02h",
                 $time, act.done, act.status, act.len, act.count, act.rbyte);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [8:0]  cfg_data_i;

  path_scoreboard sb;
  bit          no_idle;
  bit          hold_request;
  int unsigned hold_left;
  int unsigned sent;
  int unsigned quiet_cycles;

  path_dot_segment_normalizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // input notes come before result checks within one edge
  always @(posedge clk_i) begin
    path_result_t act;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_input(s_axis_tuser, s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[15:8]);
      if (m_axis_tvalid && m_axis_tready) begin
        act.done   = m_axis_tlast;
        act.status = m_axis_tuser;
        act.len    = m_axis_tdata[8:0];
        act.count  = m_axis_tdata[16:9];
        act.rbyte  = m_axis_tdata[24:17];
        sb.check_result(act);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  // receiver with random stalls and one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 6);
    end
  end

  task automatic send(logic [1:0] c, logic [7:0] ch, bit lst, logic [7:0] ri);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {ri, ch};
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (!no_idle && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic part(logic [1:0] c, string s, bit lst);
    for (int i = 0; i < s.len(); i++)
      send(c, s[i], lst && (i == s.len() - 1), 8'($urandom_range(0, 255)));
  endtask

  // only entries written before are read back
  task automatic read_back(int unsigned hint);
    int unsigned start, idx;
    bit found;
    found = 1'b0;
    start = ($urandom_range(0, 3) != 0) ? $urandom_range(0, hint) : $urandom_range(0, 255);
    for (int k = 0; k < STORE_BYTES && !found; k++) begin
      idx = (start + k) % STORE_BYTES;
      if (sb.written[idx]) found = 1'b1;
    end
    if (found)
      send(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 8'(idx));
    else
      send(CMD_NOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
           8'($urandom_range(0, 255)));
  endtask

  task automatic write_capacity(logic [8:0] v);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.cap = v;
  endtask

  function automatic logic [7:0] name_char();
    int unsigned r;
    string pool;
    pool = "abcdXYZ09.-_~";
    r = $urandom_range(0, 99);
    if (r < 2) return CH_NUL;
    if (r < 6) return 8'($urandom_range(1, 255));
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  task automatic send_path(logic [1:0] c, bit absolute, bit lst);
    logic [7:0] q[$];
    int unsigned n, kind, len;
    if (absolute) q.push_back(CH_SLASH);
    n = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
      end else if (kind < 25) q.push_back(CH_DOT);
      else if (kind < 40) begin
        q.push_back(CH_DOT);
        q.push_back(CH_DOT);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
        repeat (len) q.push_back(name_char());
      end
      if (i != n - 1 || $urandom_range(0, 3) == 0) begin
        q.push_back(CH_SLASH);
        if ($urandom_range(0, 5) == 0) q.push_back(CH_SLASH);
      end
    end
    if (q.size() == 0) q.push_back(absolute ? CH_SLASH : name_char());
    foreach (q[i])
      send(c, q[i], lst && (i == q.size() - 1), 8'($urandom_range(0, 255)));
  endtask

  task automatic run_sequence();
    if ($urandom_range(0, 99) < 75) begin
      if ($urandom_range(0, 4) != 0)
        send_path(CMD_BASE, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
      if ($urandom_range(0, 9) == 0) begin
        send_path(CMD_NEW, 1'($urandom_range(0, 1)), 1'b0);
        send_path(CMD_BASE, 1'b1, 1'b1);
      end
      send_path(CMD_NEW, 1'($urandom_range(0, 1)), 1'b1);
      repeat ($urandom_range(0, 4)) read_back(sb.last_len + 1);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 3) == 0) read_back(255);
        else send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic directed();
    send(CMD_NOP, 8'hFF, 1'b1, 8'hFF);
    part(CMD_BASE, "/usr//./lib/../share", 1'b1);
    part(CMD_NEW, "doc/./x/..", 1'b1);
    for (int i = 0; i < 12; i++) send(CMD_READ, 8'h00, 1'b0, 8'(i));
    part(CMD_NEW, "/abs/../../q", 1'b1);
    part(CMD_NEW, "rel", 1'b1);
    part(CMD_NEW, "/..", 1'b1);
    // invalid base, then relative path with no base at all
    part(CMD_BASE, "ab", 1'b1);
    part(CMD_NEW, "c", 1'b1);
    part(CMD_NEW, "d", 1'b1);
    // zero byte cuts the base short
    part(CMD_BASE, "/ab", 1'b0);
    send(CMD_BASE, CH_NUL, 1'b0, 8'h00);
    part(CMD_BASE, "zz", 1'b1);
    part(CMD_NEW, "..", 1'b1);
    // part switches in both directions
    part(CMD_BASE, "/m/n", 1'b0);
    part(CMD_NEW, "o", 1'b1);
    part(CMD_NEW, "/p", 1'b0);
    part(CMD_BASE, "/r", 1'b1);
    part(CMD_NEW, "s", 1'b1);
    send(CMD_NEW, CH_SLASH, 1'b0, 8'h00);
    send(CMD_NEW, 8'hFF, 1'b0, 8'h00);
    send(CMD_NEW, 8'h80, 1'b1, 8'h00);
    for (int i = 0; i < 4; i++) send(CMD_READ, 8'hFF, 1'b1, 8'(i));
    // base overflows, relative new path carries that overflow
    send(CMD_BASE, CH_SLASH, 1'b0, 8'h00);
    repeat (260) send(CMD_BASE, "q", 1'b0, 8'h00);
    send(CMD_BASE, "q", 1'b1, 8'h00);
    part(CMD_NEW, "x", 1'b1);
    // needed length saturates
    send(CMD_BASE, CH_SLASH, 1'b0, 8'h00);
    for (int i = 0; i < 12; i++) begin
      repeat (19) send(CMD_BASE, "k", 1'b0, 8'h00);
      send(CMD_BASE, CH_SLASH, i == 11, 8'h00);
    end
    repeat (280) send(CMD_NEW, "z", 1'b0, 8'h00);
    send(CMD_NEW, "z", 1'b1, 8'h00);
  endtask

  initial begin
    logic [8:0] caps[10];
    int unsigned phase_start;
    caps = '{9'd2, 9'd0, 9'd1, 9'd511, 9'd300, 9'd16, 9'd40, 9'd100, 9'd257, 9'd256};
    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    no_idle       = 1'b0;
    hold_request  = 1'b0;
    hold_left     = 0;
    sent          = 0;
    quiet_cycles  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_capacity(CAP_RESET);
    directed();
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      no_idle = (p == 3);
      if (p == 5) hold_request = 1'b1;
      phase_start = sent;
      while (sent < phase_start + 45) run_sequence();
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Covered %0d inputs, %0d results: %0d path ends (%0d overflow,",
             sb.n_in, sb.n_out, sb.n_done, sb.n_ovf);
    $display("  %0d not absolute), %0d reads", sb.n_abs, sb.n_reads);
    $display("Capacity settings 2..511 incl. out-of-range values, one long output hold-off");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ path_dot_segment_normalizer_unit.f @@
rtl/core/pdsn_pkg.sv
rtl/core/pdsn_seg_stack.sv
rtl/core/pdsn_path_store.sv
rtl/core/pdsn_resolve.sv
rtl/core/path_dot_segment_normalizer_unit.sv
tb/sv/tb_top.sv
